### src/string_intern_hash_table_top_macros.svh
// Assertion macros for the string intern hash table.
// Used by string_intern_hash_table_top; needs clk and arst_n in scope.
`ifndef STRING_INTERN_HASH_TABLE_TOP_MACROS_SVH
`define STRING_INTERN_HASH_TABLE_TOP_MACROS_SVH

// expression holds at every clock edge outside reset
`define SIH_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the cycle after antecedent
`define SIH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sih_pkg.sv
// Shared types and constants of the string intern hash table.
// No dependencies; imported by string_intern_hash_table_top.
package sih_pkg;

	localparam int STATUS_W = 3;
	localparam int OFFSET_W = 12;
	localparam int LENGTH_W = 7;
	localparam int SLOT_W   = 8;
	localparam int TSLOTS_W = 9;
	localparam int ABYTES_W = 13;
	localparam int CFG_W    = 13;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [TSLOTS_W-1:0] TSLOTS_RST = 9'd256;
	localparam logic [ABYTES_W-1:0] ABYTES_RST = 13'd4096;

	typedef enum logic [0:0] {
		CFG_TABLE_SLOTS = 1'b0,
		CFG_ARENA_BYTES = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_INTERN = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_ALT    = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_TBL_FULL  = 3'd3,
		ST_ARN_FULL  = 3'd4,
		ST_TOO_LONG  = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

endpackage

### src/string_intern_hash_table_top.sv
// String intern hash table: FNV-1a hash, linear probing, byte arena.
// Depends on sih_pkg and string_intern_hash_table_top_macros.svh.
//
// Input beats carry one byte each (req_type, byte_value, last_byte). A
// non-last byte is absorbed. A beat with req_type REQ_CLEAR empties the
// table at once and yields a cleared result. A last byte starts a sequence
// run by one shared step unit: bit-serial remainder (hash modulo slot count),
// then per probed slot a check that stops at an empty slot or compares the
// metadata and each byte of an occupied one, a step to settle a miss, a read
// and write of each byte plus a terminator to copy an inserted string, and a
// load of the result register. in_stall stays high while the sequence runs.
// Overlong strings and clears answer in the cycle after their beat.
// Each result beat sits in an output register; while out_stall holds it,
// in_stall stays high as well.
// Reset empties the table and arena and sets table_slots 256, arena_bytes
// 4096; no clearing pass is needed.
`include "string_intern_hash_table_top_macros.svh"

module string_intern_hash_table_top #(
	parameter int SLOTS   = 256,
	parameter int ARENA   = 4096,
	parameter int MAX_LEN = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sih_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  byte_value,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sih_pkg::STATUS_W-1:0] status,
	output logic [sih_pkg::OFFSET_W-1:0] string_offset,
	output logic [sih_pkg::LENGTH_W-1:0] string_length,
	output logic [sih_pkg::SLOT_W-1:0]   slot_index
);
	import sih_pkg::*;

	localparam int IW  = $clog2(SLOTS);
	localparam int SW  = $clog2(SLOTS + 1);
	localparam int RW  = SW + 1;
	localparam int AW  = $clog2(ARENA);
	localparam int AUW = $clog2(ARENA + 1);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int SIW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int MW  = 32 + LW + AW;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_SLOT, S_META, S_BRD, S_BCMP,
		S_MISS, S_CRD, S_CWR, S_TERM, S_RESP
	} state_t;

	state_t               state_q;
	logic [31:0]          hash_q, div_sh_q;
	logic [LW-1:0]        stg_cnt_q, len_q, byte_q;
	logic                 over_q, where_none_q, oob_q;
	logic [1:0]           req_q;
	logic [RW-1:0]        rem_q;
	logic [4:0]           div_cnt_q;
	logic [IW-1:0]        slot_q, where_q;
	logic [SW-1:0]        probe_cnt_q, used_q;
	logic [SLOTS-1:0]     valid_q;
	logic [AUW-1:0]       arena_used_q;
	logic [TSLOTS_W-1:0]  table_slots_q;
	logic [ABYTES_W-1:0]  arena_bytes_q;
	logic                 out_valid_q;
	status_t              status_q, res_status_q;
	logic [OFFSET_W-1:0]  offset_q, res_offset_q;
	logic [LENGTH_W-1:0]  length_q, res_length_q;
	logic [SLOT_W-1:0]    slot_idx_q, res_slot_q;

	logic [MW-1:0]        meta_mem [SLOTS];
	logic [7:0]           arena_mem [ARENA];
	logic [7:0]           stg_mem [MAX_LEN];
	logic [MW-1:0]        meta_rd_q;
	logic [7:0]           arena_rd_q, stg_rd_q;

	logic [SW-1:0]        eff_n;
	logic [31:0]          eff_arena, need_bytes, hash_nxt, rd_sum;
	logic [RW-1:0]        div_shift, div_nxt;
	logic [31:0]          m_hash;
	logic [LW-1:0]        m_len;
	logic [AW-1:0]        m_off, arena_waddr;
	logic [SW-1:0]        cnt_inc, slot_inc;
	logic                 in_acc, out_free, arena_we, meta_we, done_byte;
	logic [7:0]           arena_wdata;

	assign eff_n = (table_slots_q == '0) ? SW'(1) :
		((32'(table_slots_q) > 32'(SLOTS)) ? SW'(SLOTS) : SW'(table_slots_q));
	assign eff_arena = (32'(arena_bytes_q) > 32'(ARENA)) ? 32'(ARENA) : 32'(arena_bytes_q);
	assign need_bytes = 32'(arena_used_q) + 32'(len_q) + 32'd1;
	assign hash_nxt = 32'((hash_q ^ {24'd0, byte_value}) * FNV_PRIME);
	assign div_shift = {rem_q[RW-2:0], div_sh_q[31]};
	assign div_nxt = (div_shift >= RW'(eff_n)) ? (div_shift - RW'(eff_n)) : div_shift;
	assign {m_hash, m_len, m_off} = meta_rd_q;
	assign rd_sum = 32'(m_off) + 32'(byte_q);
	assign cnt_inc = probe_cnt_q + SW'(1);
	assign slot_inc = SW'(slot_q) + SW'(1);
	assign done_byte = (byte_q + LW'(1)) == len_q;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign arena_we = (state_q == S_CWR) || (state_q == S_TERM);
	assign arena_waddr = AW'(arena_used_q) + AW'(byte_q);
	assign arena_wdata = (state_q == S_CWR) ? stg_rd_q : 8'd0;
	assign meta_we = (state_q == S_TERM);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign string_offset = offset_q;
	assign string_length = length_q;
	assign slot_index    = slot_idx_q;

	always_ff @(posedge clk) begin
		if (in_acc && req_type != REQ_CLEAR && 32'(stg_cnt_q) < 32'(MAX_LEN)) begin
			stg_mem[stg_cnt_q[SIW-1:0]] <= byte_value;
		end
		stg_rd_q <= stg_mem[byte_q[SIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (arena_we) begin
			arena_mem[arena_waddr] <= arena_wdata;
		end
		arena_rd_q <= arena_mem[AW'(rd_sum)];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[where_q] <= {hash_q, len_q, AW'(arena_used_q)};
		end
		meta_rd_q <= meta_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			hash_q        <= FNV_BASIS;
			stg_cnt_q     <= '0;
			over_q        <= 1'b0;
			valid_q       <= '0;
			used_q        <= '0;
			arena_used_q  <= '0;
			table_slots_q <= TSLOTS_RST;
			arena_bytes_q <= ABYTES_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TABLE_SLOTS: table_slots_q <= cfg_data[TSLOTS_W-1:0];
					CFG_ARENA_BYTES: arena_bytes_q <= cfg_data[ABYTES_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_CLEAR) begin
							valid_q      <= '0;
							used_q       <= '0;
							arena_used_q <= '0;
							stg_cnt_q    <= '0;
							over_q       <= 1'b0;
							hash_q       <= FNV_BASIS;
							out_valid_q  <= 1'b1;
							status_q     <= ST_CLEARED;
							offset_q     <= '0;
							length_q     <= '0;
							slot_idx_q   <= '0;
						end else if (last_byte) begin
							stg_cnt_q <= '0;
							over_q    <= 1'b0;
							if (over_q || 32'(stg_cnt_q) >= 32'(MAX_LEN)) begin
								hash_q      <= FNV_BASIS;
								out_valid_q <= 1'b1;
								status_q    <= ST_TOO_LONG;
								offset_q    <= '0;
								length_q    <= '0;
								slot_idx_q  <= '0;
							end else begin
								hash_q    <= hash_nxt;
								div_sh_q  <= hash_nxt;
								len_q     <= stg_cnt_q + LW'(1);
								req_q     <= req_type;
								rem_q     <= '0;
								div_cnt_q <= '0;
								state_q   <= S_DIV;
							end
						end else begin
							hash_q <= hash_nxt;
							if (32'(stg_cnt_q) < 32'(MAX_LEN)) begin
								stg_cnt_q <= stg_cnt_q + LW'(1);
							end else begin
								over_q <= 1'b1;
							end
						end
					end
				end
				S_DIV: begin
					rem_q     <= div_nxt;
					div_sh_q  <= {div_sh_q[30:0], 1'b0};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						slot_q       <= IW'(div_nxt);
						probe_cnt_q  <= '0;
						where_none_q <= 1'b0;
						state_q      <= S_SLOT;
					end
				end
				S_SLOT: begin
					if (!valid_q[slot_q]) begin
						where_q <= slot_q;
						state_q <= S_MISS;
					end else begin
						state_q <= S_META;
					end
				end
				S_META, S_BCMP: begin
					if ((state_q == S_META && m_hash == hash_q && m_len == len_q) ||
					    (state_q == S_BCMP && !oob_q && arena_rd_q == stg_rd_q &&
					     !done_byte)) begin
						byte_q  <= (state_q == S_META) ? '0 : byte_q + LW'(1);
						state_q <= S_BRD;
					end else if (state_q == S_BCMP && !oob_q && arena_rd_q == stg_rd_q) begin
						res_status_q <= ST_FOUND;
						res_offset_q <= OFFSET_W'(m_off);
						res_length_q <= LENGTH_W'(m_len);
						res_slot_q   <= SLOT_W'(slot_q);
						state_q      <= S_RESP;
					end else if (cnt_inc == eff_n) begin
						where_none_q <= 1'b1;
						state_q      <= S_MISS;
					end else begin
						probe_cnt_q <= cnt_inc;
						slot_q      <= (slot_inc == eff_n) ? '0 : IW'(slot_inc);
						state_q     <= S_SLOT;
					end
				end
				S_BRD: begin
					oob_q   <= rd_sum >= 32'(ARENA);
					state_q <= S_BCMP;
				end
				S_MISS: begin
					res_offset_q <= '0;
					res_length_q <= '0;
					res_slot_q   <= '0;
					state_q      <= S_RESP;
					if (req_q != REQ_INTERN) begin
						res_status_q <= ST_NOT_FOUND;
					end else if (used_q >= eff_n || where_none_q) begin
						res_status_q <= ST_TBL_FULL;
					end else if (need_bytes > eff_arena) begin
						res_status_q <= ST_ARN_FULL;
					end else begin
						byte_q  <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					byte_q  <= byte_q + LW'(1);
					state_q <= done_byte ? S_TERM : S_CRD;
				end
				S_TERM: begin
					valid_q[where_q] <= 1'b1;
					used_q           <= used_q + SW'(1);
					arena_used_q     <= arena_used_q + AUW'(len_q) + AUW'(1);
					res_status_q     <= ST_INSERTED;
					res_offset_q     <= OFFSET_W'(arena_used_q);
					res_length_q     <= LENGTH_W'(len_q);
					res_slot_q       <= SLOT_W'(where_q);
					state_q          <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						offset_q    <= res_offset_q;
						length_q    <= res_length_q;
						slot_idx_q  <= res_slot_q;
						hash_q      <= FNV_BASIS;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SIH_ASSERT_ALWAYS(a_used_bound, 32'(used_q) <= 32'(SLOTS), "used slot count overflow")
	`SIH_ASSERT_ALWAYS(a_arena_bound, 32'(arena_used_q) <= 32'(ARENA), "arena use overflow")
	`SIH_ASSERT_ALWAYS(a_slot_range, state_q != S_SLOT || SW'(slot_q) < eff_n,
		"probe slot out of range")
	`SIH_ASSERT_NEXT(a_clear_empties, in_acc && req_type == REQ_CLEAR,
		used_q == '0 && arena_used_q == '0 && out_valid_q && status_q == ST_CLEARED,
		"clear did not empty store")

endmodule
